[rtl/mcf_pkg.sv]
// Shared types and constants for the message chunk fragmenter.
// Used by mcf_front, mcf_queue, mcf_back and message_chunk_fragmenter_unit.
package mcf_pkg;

   // Sizes
   localparam int MAX_PACKET_BYTES = 512;
   localparam int MTU_W            = 10;
   localparam int CHUNK_W          = 9;
   localparam int LEN_W            = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   // Tag bytes
   localparam logic [7:0] TAG_FIRST  = 8'h00;
   localparam logic [7:0] TAG_MIDDLE = 8'h01;
   localparam logic [7:0] TAG_LAST   = 8'h80;

   // Framing constants
   localparam logic [MTU_W-1:0]   MIN_MTU       = MTU_W'(23);
   localparam logic [MTU_W-1:0]   MTU_OVERHEAD  = MTU_W'(4);
   localparam logic [MTU_W-1:0]   LIMIT_CEILING = MTU_W'(MAX_PACKET_BYTES - 1);
   localparam logic [CHUNK_W-1:0] HEADER_FILL   = CHUNK_W'(3);
   localparam logic [CHUNK_W-1:0] CHUNK_RESET   = CHUNK_W'(19);

   // Operation codes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Work kinds handed from front to back
   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_TAG_DATA
   } cmd_kind_type;

   typedef struct packed {
      logic             operation;
      logic [7:0]       type_byte;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       message_end;
      logic       run_last;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       tag_byte;
      logic [7:0]       first_byte;
      logic [LEN_W-1:0] length;
      logic             packet_end;
      logic             message_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/mcf_front.sv]
// Front end: accepts items, keeps framing state, emits one work command per start
// item or open-message payload item. Holds the MTU register. Depends on mcf_pkg.
module mcf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  mcf_pkg::req_item_type     req_data,
   input  logic                      csr_write,
   input  logic [mcf_pkg::MTU_W-1:0] csr_data,
   output logic                      push,
   output mcf_pkg::cmd_type          push_cmd
);
   import mcf_pkg::*;

   logic [MTU_W-1:0]   att_mtu_ff;
   logic               active_ff, active_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [CHUNK_W-1:0] fill_ff, fill_in;
   logic [CHUNK_W-1:0] limit_ff, limit_in;

   logic               accept;
   logic [MTU_W-1:0]   mtu_eff;
   logic [MTU_W-1:0]   lim_wide;
   logic [CHUNK_W-1:0] start_limit;
   logic               start_done;
   logic               need_tag;
   logic [CHUNK_W-1:0] fill_base;
   logic [CHUNK_W-1:0] fill_next;
   logic [LEN_W-1:0]   left_next;

   assign accept = req_valid && !req_stall;

   // packet size from the MTU register
   always_comb begin
      mtu_eff     = (att_mtu_ff < MIN_MTU) ? MIN_MTU : att_mtu_ff;
      lim_wide    = mtu_eff - MTU_OVERHEAD;
      start_limit = (lim_wide > LIMIT_CEILING) ? LIMIT_CEILING[CHUNK_W-1:0]
                                               : lim_wide[CHUNK_W-1:0];
   end

   // classify the item and work out the next framing state
   always_comb begin
      start_done = (req_data.payload_length == '0);
      need_tag   = (fill_ff >= limit_ff);
      fill_base  = need_tag ? '0 : fill_ff;
      fill_next  = fill_base + CHUNK_W'(1);
      left_next  = left_ff - LEN_W'(1);

      active_in  = active_ff;
      left_in    = left_ff;
      fill_in    = fill_ff;
      limit_in   = limit_ff;
      push       = 1'b0;

      push_cmd.kind        = CMD_START;
      push_cmd.tag_byte    = TAG_FIRST;
      push_cmd.first_byte  = req_data.type_byte;
      push_cmd.length      = req_data.payload_length;
      push_cmd.packet_end  = start_done || (HEADER_FILL >= start_limit);
      push_cmd.message_end = start_done;

      if (accept) begin
         unique case (req_data.operation)
            OP_START: begin
               push      = 1'b1;
               limit_in  = start_limit;
               fill_in   = HEADER_FILL;
               left_in   = req_data.payload_length;
               active_in = !start_done;
            end
            OP_PAYLOAD: begin
               if (!active_ff || left_ff == '0) begin
                  active_in = 1'b0;
               end else begin
                  push                 = 1'b1;
                  push_cmd.kind        = need_tag ? CMD_TAG_DATA : CMD_DATA;
                  push_cmd.tag_byte    = (left_ff <= LEN_W'(limit_ff)) ? TAG_LAST
                                                                      : TAG_MIDDLE;
                  push_cmd.first_byte  = req_data.data_byte;
                  push_cmd.message_end = (left_next == '0);
                  push_cmd.packet_end  = (left_next == '0) || (fill_next >= limit_ff);
                  fill_in              = fill_next;
                  left_in              = left_next;
                  if (left_next == '0) begin
                     active_in = 1'b0;
                  end
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         att_mtu_ff <= MIN_MTU;
         active_ff  <= 1'b0;
         left_ff    <= '0;
         fill_ff    <= '0;
         limit_ff   <= CHUNK_RESET;
      end else begin
         if (csr_write) begin
            att_mtu_ff <= csr_data;
         end
         active_ff <= active_in;
         left_ff   <= left_in;
         fill_ff   <= fill_in;
         limit_ff  <= limit_in;
      end
   end

   // an open message always has bytes still to come
   a_active_left: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> left_ff != '0)
      else $error("active message with no bytes left");

   // the latched packet limit never falls below the limit for the minimum MTU
   a_limit_min: assert property (@(posedge clock) disable iff (reset)
      limit_ff >= CHUNK_RESET)
      else $error("packet limit below minimum");

   // fill never passes the packet limit while a message is open
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> fill_ff <= limit_ff)
      else $error("packet fill above limit");

endmodule

[rtl/mcf_queue.sv]
// Short command queue between the front and back ends.
// Depends on mcf_pkg.
module mcf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mcf_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output mcf_pkg::cmd_type          head_cmd,
   output mcf_pkg::queue_status_type status
);
   import mcf_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/mcf_back.sv]
// Back end: expands each queued command into output bytes, one per cycle
// unless stalled, into a registered result stage. Depends on mcf_pkg.
module mcf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mcf_pkg::cmd_type          head_cmd,
   input  mcf_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mcf_pkg::rsp_item_type     rsp_data
);
   import mcf_pkg::*;

   logic [1:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;
   rsp_item_type cur;
   logic         slot_free;
   logic         load;

   assign slot_free = !valid_ff || !rsp_stall;
   assign load      = slot_free && !status.empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // pick the byte for the current step of the head command
   always_comb begin
      cur.out_byte    = head_cmd.first_byte;
      cur.packet_end  = 1'b0;
      cur.message_end = 1'b0;
      cur.run_last    = 1'b0;
      unique case (head_cmd.kind)
         CMD_START: begin
            unique case (idx_ff)
               2'd0:    cur.out_byte = TAG_FIRST;
               2'd1:    cur.out_byte = head_cmd.first_byte;
               2'd2:    cur.out_byte = head_cmd.length[7:0];
               default: begin
                  cur.out_byte    = head_cmd.length[15:8];
                  cur.packet_end  = head_cmd.packet_end;
                  cur.message_end = head_cmd.message_end;
                  cur.run_last    = 1'b1;
               end
            endcase
         end
         CMD_TAG_DATA: begin
            if (idx_ff == 2'd0) begin
               cur.out_byte = head_cmd.tag_byte;
            end else begin
               cur.packet_end  = head_cmd.packet_end;
               cur.message_end = head_cmd.message_end;
               cur.run_last    = 1'b1;
            end
         end
         default: begin
            cur.packet_end  = head_cmd.packet_end;
            cur.message_end = head_cmd.message_end;
            cur.run_last    = 1'b1;
         end
      endcase
   end

   // step control and output stage
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = cur;
         if (cur.run_last) begin
            pop    = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (slot_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // a message end always closes the packet and the item's run
   a_mend_closes: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.message_end) |-> (data_ff.packet_end && data_ff.run_last))
      else $error("message end without packet end or run end");

   // mid-command steps only happen with a command at the queue head
   a_mid_has_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !status.empty)
      else $error("step count set with empty queue");

   // finishing a command returns the step count to zero
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (load && cur.run_last) |=> (idx_ff == 2'd0))
      else $error("step count not cleared after last byte");

endmodule

[rtl/message_chunk_fragmenter_unit.sv]
// Top level of the message chunk fragmenter: front end, command queue, back end.
// Depends on mcf_pkg, mcf_front, mcf_queue and mcf_back.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_data  (req_item_type)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (rsp_item_type)
//   csr     | in        | csr_valid / csr_ready  | csr_data  (att_mtu, 10 bits)
//
// The front takes one item per cycle while the 4-entry command queue has room.
// The back emits one byte per cycle from the registered output stage unless stalled:
// a start item gives 4 bytes, an open message's payload item 1 or 2, so throughput is
// set by the back's byte rate. An item goes into the queue, then into the output stage.
// Reset is synchronous: queue emptied, no message open, MTU 23, packet limit 19.
// rsp_stall holds the output stage; the queue fills and then req_stall rises.
module message_chunk_fragmenter_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mcf_pkg::req_item_type     req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mcf_pkg::rsp_item_type     rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mcf_pkg::MTU_W-1:0] csr_data
);
   import mcf_pkg::*;

   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head_cmd;
   queue_status_type status;

   assign csr_ready = 1'b1;
   assign req_stall = status.full;

   // item intake and framing state
   mcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // decoupling queue
   mcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   // byte emission
   mcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
